// ----- hw/rtl/prr_pkg.sv -----
`default_nettype none
package prr_pkg;

    localparam int unsigned XLEN       = 64;
    localparam int unsigned INST_W     = 32;
    localparam int unsigned IN_DATA_W  = 488;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_DATA_W = 200;

    // Status register bit positions.
    localparam int unsigned B_SIE    = 1;
    localparam int unsigned B_MIE    = 3;
    localparam int unsigned B_SPIE   = 5;
    localparam int unsigned B_MPIE   = 7;
    localparam int unsigned B_SPP    = 8;
    localparam int unsigned B_MPP_LO = 11;
    localparam int unsigned B_MPP_HI = 12;
    localparam int unsigned B_MPRV   = 17;
    localparam int unsigned B_TVM    = 20;
    localparam int unsigned B_TW     = 21;

    typedef enum logic [2:0] {
        OP_IRQ_CHECK = 3'd0,
        OP_WFI       = 3'd1,
        OP_SRET      = 3'd2,
        OP_MRET      = 3'd3,
        OP_SFENCE    = 3'd4
    } t_op;

    localparam logic [1:0] MODE_U   = 2'd0;
    localparam logic [1:0] MODE_S   = 2'd1;
    localparam logic [1:0] MODE_RSV = 2'd2;
    localparam logic [1:0] MODE_M   = 2'd3;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [1:0]        priv_mode;
        logic [XLEN-1:0]   status_word;
        logic [XLEN-1:0]   irq_pending;
        logic [XLEN-1:0]   irq_enable;
        logic [XLEN-1:0]   irq_delegate;
        logic [XLEN-1:0]   sup_irq_enable;
        logic [XLEN-1:0]   machine_return_pc;
        logic [XLEN-1:0]   sup_return_pc;
        logic              in_trap;
        logic [INST_W-1:0] instruction_word;
    } t_prr_in;

    typedef struct packed {
        logic [XLEN-1:0] new_status_word;
        logic [1:0]      new_priv_mode;
        logic            redirect;
        logic [XLEN-1:0] new_pc;
        logic            illegal_trap;
        logic [XLEN-1:0] trap_value;
        logic            wait_irq;
        logic            irq_ready;
        logic            flush_translation;
        logic            clear_trap;
    } t_prr_out;

endpackage
`default_nettype wire

// ----- hw/rtl/riscv_privileged_return_unit.sv -----
`default_nettype none
// A transaction accepted on the slave side is captured in an input register, and its result is
// captured in a result register that drives the master side.
// Throughput: one transaction per cycle; an input register feeds the decode logic and a
// result register drives the master side, each advancing whenever the next stage frees up.
// Reset: synchronous, active low; it empties both stages. The data registers are not reset.
module riscv_privileged_return_unit
    import prr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // From bit 0: priv_mode[1:0], status_word[65:2], irq_pending[129:66],
    // irq_enable[193:130], irq_delegate[257:194], sup_irq_enable[321:258],
    // machine_return_pc[385:322], sup_return_pc[449:386], in_trap[450],
    // instruction_word[482:451], zero pad[487:483].
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // opcode[2:0].
    input  wire logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // From bit 0: new_status_word[63:0], new_priv_mode[65:64], redirect[66],
    // new_pc[130:67], illegal_trap[131], trap_value[195:132], wait_irq[196],
    // irq_ready[197], flush_translation[198], clear_trap[199].
    output logic [OUT_DATA_W-1:0]      o_m_tdata
);

    logic     r_in_valid;
    t_prr_in  r_in;
    logic     r_out_valid;
    t_prr_out r_out;
    t_prr_in  n_in;
    t_prr_out n_out;
    logic     out_load;
    logic     in_load;

    assign out_load   = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || out_load;
    assign in_load    = i_s_tvalid && o_s_tready;

    always_comb begin
        n_in.opcode            = i_s_tuser;
        n_in.priv_mode         = i_s_tdata[1:0];
        n_in.status_word       = i_s_tdata[65:2];
        n_in.irq_pending       = i_s_tdata[129:66];
        n_in.irq_enable        = i_s_tdata[193:130];
        n_in.irq_delegate      = i_s_tdata[257:194];
        n_in.sup_irq_enable    = i_s_tdata[321:258];
        n_in.machine_return_pc = i_s_tdata[385:322];
        n_in.sup_return_pc     = i_s_tdata[449:386];
        n_in.in_trap           = i_s_tdata[450];
        n_in.instruction_word  = i_s_tdata[482:451];
    end

    prr_exec u_exec (
        .i_item (r_in),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= n_in;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.clear_trap, r_out.flush_translation, r_out.irq_ready,
                         r_out.wait_irq, r_out.trap_value, r_out.illegal_trap,
                         r_out.new_pc, r_out.redirect, r_out.new_priv_mode,
                         r_out.new_status_word};

endmodule
`default_nettype wire

// ----- hw/rtl/prr_irq.sv -----
`default_nettype none
module prr_irq
    import prr_pkg::*;
(
    input  wire logic [1:0]      i_mode,
    input  wire logic [XLEN-1:0] i_status,
    input  wire logic [XLEN-1:0] i_pending,
    input  wire logic [XLEN-1:0] i_enable,
    input  wire logic [XLEN-1:0] i_delegate,
    input  wire logic [XLEN-1:0] i_sup_enable,
    output logic                 o_ready,
    output logic                 o_any_pending
);

    logic [XLEN-1:0] pend_en;

    assign pend_en       = i_pending & i_enable;
    assign o_any_pending = |pend_en;

    always_comb begin
        case (i_mode)
            MODE_M:  o_ready = i_status[B_MIE] && |(pend_en & ~i_delegate);
            MODE_S:  o_ready = i_status[B_SIE] && |(pend_en & i_delegate & i_sup_enable);
            MODE_U:  o_ready = |pend_en;
            default: o_ready = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/prr_exec.sv -----
`default_nettype none
module prr_exec
    import prr_pkg::*;
(
    input  wire t_prr_in i_item,
    output t_prr_out     o_res
);

    logic       irq_ready;
    logic       any_pending;
    logic [1:0] mpp;
    logic       wfi_bad;
    logic       sfence_bad;

    prr_irq u_irq (
        .i_mode        (i_item.priv_mode),
        .i_status      (i_item.status_word),
        .i_pending     (i_item.irq_pending),
        .i_enable      (i_item.irq_enable),
        .i_delegate    (i_item.irq_delegate),
        .i_sup_enable  (i_item.sup_irq_enable),
        .o_ready       (irq_ready),
        .o_any_pending (any_pending)
    );

    assign mpp        = i_item.status_word[B_MPP_HI:B_MPP_LO];
    assign wfi_bad    = (i_item.priv_mode == MODE_U) ||
                        (i_item.status_word[B_TW] && (i_item.priv_mode != MODE_M));
    assign sfence_bad = (i_item.priv_mode == MODE_U) ||
                        ((i_item.priv_mode == MODE_S) && i_item.status_word[B_TVM]);

    always_comb begin
        o_res                   = '0;
        o_res.new_status_word   = i_item.status_word;
        o_res.new_priv_mode     = i_item.priv_mode;
        o_res.irq_ready         = irq_ready;
        case (t_op'(i_item.opcode))
            OP_IRQ_CHECK: begin
                o_res.irq_ready = irq_ready;
            end
            OP_WFI: begin
                // An illegal WFI inside a trap handler is dropped silently.
                if (wfi_bad) begin
                    o_res.illegal_trap = ~i_item.in_trap;
                end else begin
                    o_res.wait_irq = ~any_pending;
                end
            end
            OP_SRET: begin
                if (i_item.priv_mode == MODE_U) begin
                    o_res.illegal_trap = 1'b1;
                end else begin
                    o_res.new_priv_mode                = {1'b0, i_item.status_word[B_SPP]};
                    o_res.new_status_word[B_SIE]       = i_item.status_word[B_SPIE];
                    o_res.new_status_word[B_SPIE]      = 1'b1;
                    o_res.new_status_word[B_SPP]       = 1'b0;
                    o_res.redirect                     = 1'b1;
                    o_res.new_pc                       = i_item.sup_return_pc;
                    o_res.clear_trap                   = 1'b1;
                end
            end
            OP_MRET: begin
                if (mpp != MODE_M) begin
                    o_res.new_status_word[B_MPRV] = 1'b0;
                end
                o_res.new_status_word[B_MIE]  = i_item.status_word[B_MPIE];
                o_res.new_status_word[B_MPIE] = 1'b1;
                // A reserved previous mode leaves the current mode in place.
                if (mpp != MODE_RSV) begin
                    o_res.new_priv_mode = mpp;
                end
                o_res.new_status_word[B_MPP_HI:B_MPP_LO] = 2'b00;
                o_res.redirect   = 1'b1;
                o_res.new_pc     = i_item.machine_return_pc;
                o_res.clear_trap = 1'b1;
            end
            OP_SFENCE: begin
                if (sfence_bad) begin
                    o_res.illegal_trap = 1'b1;
                    o_res.trap_value   = {{(XLEN-INST_W){1'b0}}, i_item.instruction_word};
                end else begin
                    o_res.flush_translation = 1'b1;
                end
            end
            default: begin
                o_res.irq_ready = irq_ready;
            end
        endcase
    end

endmodule
`default_nettype wire
